// ----- sv/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

  // Header decode phases, one-hot
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // Length codes and field masks of the second header byte
  localparam logic [7:0] MaskFlagBit = 8'h80;
  localparam logic [7:0] Len7Mask    = 8'h7F;
  localparam logic [6:0] Len7Ext16   = 7'd126;
  localparam logic [6:0] Len7Ext64   = 7'd127;

  // Byte counts of the extended length and key fields
  localparam logic [3:0] Ext16Bytes  = 4'd2;
  localparam logic [3:0] Ext64Bytes  = 4'd8;
  localparam logic [3:0] KeyBytes    = 4'd4;

  // Result queue between front and back
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCountW  = $clog2(QDepth + 1);

  // One classified result beat: raw byte plus the key byte to apply
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic       empty;
  } q_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- sv/wsd_front.sv -----
`timescale 1ns / 1ps

module wsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  wsd_pkg::q_status_t q_status_i,
  output logic               q_push_o,
  output wsd_pkg::q_entry_t  q_entry_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic        mask_on_q, mask_on_d;
  logic [1:0]  key_idx_q, key_idx_d;

  logic        accept;
  logic        emit;
  q_entry_t    entry;
  logic [6:0]  len7;
  logic [63:0] ext_len;
  logic [63:0] remain_dec;
  logic [7:0]  key_byte;

  // Always leave room for a result, so no byte waits on its own classification
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign len7       = in_byte_i[6:0] & Len7Mask[6:0];
  assign ext_len    = {remain_q[55:0], in_byte_i};
  assign remain_dec = remain_q - 64'd1;

  // Key byte for the next payload beat, first key byte in the top bits
  always_comb begin
    unique case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Header parse and payload classification
  always_comb begin
    phase_d    = phase_q;
    ext_left_d = ext_left_q;
    remain_d   = remain_q;
    key_d      = key_q;
    mask_on_d  = mask_on_q;
    key_idx_d  = key_idx_q;
    emit       = 1'b0;
    entry      = '0;

    unique case (phase_q)
      PH_HDR1: begin
        mask_on_d = (in_byte_i & MaskFlagBit) != 8'h00;
        remain_d  = '0;
        if (len7 == Len7Ext16) begin
          ext_left_d = Ext16Bytes;
          phase_d    = PH_EXTLEN;
        end else if (len7 == Len7Ext64) begin
          ext_left_d = Ext64Bytes;
          phase_d    = PH_EXTLEN;
        end else begin
          remain_d  = {57'd0, len7};
          key_idx_d = '0;
          if (mask_on_d) begin
            ext_left_d = KeyBytes;
            phase_d    = PH_MASK;
          end else if (len7 == 7'd0) begin
            phase_d     = PH_HDR0;
            emit        = 1'b1;
            entry.last  = 1'b1;
            entry.empty = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        remain_d   = ext_len;
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == 4'd0) begin
          key_idx_d = '0;
          if (mask_on_q) begin
            ext_left_d = KeyBytes;
            phase_d    = PH_MASK;
          end else if (ext_len == 64'd0) begin
            phase_d     = PH_HDR0;
            emit        = 1'b1;
            entry.last  = 1'b1;
            entry.empty = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        key_d      = {key_q[23:0], in_byte_i};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == 4'd0) begin
          key_idx_d = '0;
          if (remain_q == 64'd0) begin
            phase_d     = PH_HDR0;
            emit        = 1'b1;
            entry.last  = 1'b1;
            entry.empty = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        key_idx_d  = key_idx_q + 2'd1;
        remain_d   = remain_dec;
        emit       = 1'b1;
        entry.data = in_byte_i;
        entry.key  = mask_on_q ? key_byte : 8'h00;
        entry.last = (remain_dec == 64'd0);
        if (entry.last) begin
          phase_d = PH_HDR0;
        end
      end
      default: begin
        // First header byte, and any unused code: skip it
        phase_d = PH_HDR1;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      ext_left_q <= '0;
      remain_q   <= '0;
      key_q      <= '0;
      mask_on_q  <= 1'b0;
      key_idx_q  <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      ext_left_q <= ext_left_d;
      remain_q   <= remain_d;
      key_q      <= key_d;
      mask_on_q  <= mask_on_d;
      key_idx_q  <= key_idx_d;
    end
  end

  assign q_push_o  = accept && emit;
  assign q_entry_o = entry;

endmodule

// ----- sv/wsd_queue.sv -----
`timescale 1ns / 1ps

module wsd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wsd_pkg::q_entry_t  push_entry_i,
  input  logic               pop_i,
  output wsd_pkg::q_entry_t  head_o,
  output wsd_pkg::q_status_t status_o
);
  import wsd_pkg::*;

  q_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCountW-1:0]   count_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == QCountW'(QDepth));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  assign head_o = mem_q[rd_ptr_q];

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCountW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCountW'(1);
      end
    end
  end

endmodule

// ----- sv/wsd_back.sv -----
`timescale 1ns / 1ps

module wsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsd_pkg::q_entry_t  head_i,
  input  wsd_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         data_byte_o,
  output logic               frame_end_o,
  output logic               empty_frame_o
);
  import wsd_pkg::*;

  logic       valid_q;
  logic [7:0] data_q;
  logic       end_q;
  logic       empty_q;

  // Load the output register whenever it is free or being drained
  assign pop_o = !q_status_i.empty && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Unmask on the way out
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q  <= head_i.data ^ head_i.key;
      end_q   <= head_i.last;
      empty_q <= head_i.empty;
    end
  end

  assign out_valid_o   = valid_q;
  assign data_byte_o   = data_q;
  assign frame_end_o   = end_q;
  assign empty_frame_o = empty_q;

endmodule

// ----- sv/websocket_frame_deframer_core.sv -----
`timescale 1ns / 1ps
// A payload or empty-frame beat is parsed and pushed into the result queue in the cycle its byte
// is accepted, then unmasked from the queue head into the output register, which drives the output.
// Throughput: one byte per cycle; the front stalls only when the two-entry result queue fills.
// Header bytes produce no output beat, except the last header byte of a zero-length frame.
// Reset (rst_ni low, asynchronous): parser back to the first header byte, queue and output empty.

module websocket_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       frame_end_o,
  output logic       empty_frame_o
);
  import wsd_pkg::*;

  logic      q_push;
  q_entry_t  q_in;
  q_entry_t  q_head;
  logic      q_pop;
  q_status_t q_status;

  // Header parse and byte classification
  wsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_entry_o  (q_in)
  );

  // Decoupling queue
  wsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .status_o     (q_status)
  );

  // Unmask and output register
  wsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .q_status_i    (q_status),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .frame_end_o   (frame_end_o),
    .empty_frame_o (empty_frame_o)
  );

  // Front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("result pushed into full queue");

  // Back never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // An empty-frame beat closes its frame and carries a zero byte
  a_empty_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_frame_o) |-> (frame_end_o && data_byte_o == 8'h00))
    else $error("malformed empty-frame beat");

endmodule
